// File: hdl/multi_task_stall_watchdog_top_assert.svh
// Assertion macros used by the stall watchdog back end.
`ifndef MULTI_TASK_STALL_WATCHDOG_TOP_ASSERT_SVH
`define MULTI_TASK_STALL_WATCHDOG_TOP_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define MTSW_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MTSW_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTSW_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mtsw_pkg.sv
// Types and constants shared by the stall watchdog modules.
`default_nettype none

package mtsw_pkg;

	// Field widths
	localparam int TW = 32;
	localparam int REQ_W = 2;
	localparam int CFG_IW = 1;

	// Request codes on the input channel
	localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FINISH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_TASK_TIMEOUT = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_IDLE_DELAY   = 1'd1;

	// Register reset values
	localparam logic [TW-1:0] TIMEOUT_RST = 32'd5000;
	localparam logic [TW-1:0] IDLE_DELAY_RST = 32'd1000;

	// Report limit per tick
	localparam int MAX_RESULTS = 16;
	localparam int RCW = $clog2(MAX_RESULTS + 1);

	// Command queue depth
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		OP_START,
		OP_FINISH,
		OP_TICK,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_SLEEP   = 2'd1,
		MODE_MONITOR = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_INC,
		ST_TICK_CHK,
		ST_SCAN,
		ST_APPLY,
		ST_FIN_CHK,
		ST_RESULT,
		ST_FLUSH
	} state_t;

	// Classified command word
	typedef struct packed {
		op_t           op;
		logic [TW-1:0] tid;
	} cmd_t;

	// Configuration register values
	typedef struct packed {
		logic [TW-1:0] timeout;
		logic [TW-1:0] idle_delay;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/mtsw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mtsw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/mtsw_front.sv
// Front end: input acceptance, request classification and configuration registers.
`default_nettype none

module mtsw_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mtsw_pkg::REQ_W-1:0]    req_type,
	input  wire logic [mtsw_pkg::TW-1:0]       task_thread,
	input  wire logic                          cfg_wen,
	input  wire logic [mtsw_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [mtsw_pkg::TW-1:0]       cfg_wdata,
	input  wire logic                          q_full,
	output logic                               q_push,
	output mtsw_pkg::cmd_t                     q_data,
	output mtsw_pkg::cfg_t                     cfg
);

	mtsw_pkg::cfg_t cfg_q;

	// Accept whenever the queue has room
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	// Classify the request
	always_comb begin
		q_data.tid = task_thread;
		case (req_type)
			mtsw_pkg::REQ_START:  q_data.op = mtsw_pkg::OP_START;
			mtsw_pkg::REQ_FINISH: q_data.op = mtsw_pkg::OP_FINISH;
			mtsw_pkg::REQ_TICK:   q_data.op = mtsw_pkg::OP_TICK;
			default:              q_data.op = mtsw_pkg::OP_NONE;
		endcase
	end

	// Configuration registers; a zero timeout is stored as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= mtsw_pkg::TIMEOUT_RST;
			cfg_q.idle_delay <= mtsw_pkg::IDLE_DELAY_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				mtsw_pkg::CFG_TASK_TIMEOUT: begin
					cfg_q.timeout <= (cfg_wdata == '0) ? mtsw_pkg::TW'(1) : cfg_wdata;
				end
				mtsw_pkg::CFG_IDLE_DELAY: begin
					cfg_q.idle_delay <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hdl/mtsw_queue.sv
// Short command queue between front end and back end.
`default_nettype none

module mtsw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  mtsw_pkg::cmd_t      push_data,
	output logic                full,
	input  wire logic           pop,
	output mtsw_pkg::cmd_t      pop_data,
	output logic                not_empty
);

	mtsw_pkg::cmd_t              entry_q [mtsw_pkg::QDEPTH];
	logic [mtsw_pkg::QAW-1:0]    wr_ptr_q;
	logic [mtsw_pkg::QAW-1:0]    rd_ptr_q;
	logic [mtsw_pkg::QCW-1:0]    cnt_q;

	assign full = (cnt_q == mtsw_pkg::QCW'(mtsw_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + mtsw_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mtsw_pkg::QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + mtsw_pkg::QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - mtsw_pkg::QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/mtsw_back.sv
// Back end: task table, slot scan sequencer and result output register.
`default_nettype none
`include "multi_task_stall_watchdog_top_assert.svh"

module mtsw_back #(
	parameter int SLOTS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  mtsw_pkg::cfg_t                  cfg,
	input  wire logic                       cmd_valid,
	input  mtsw_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      mode,
	output logic                            timeout_valid,
	output logic [mtsw_pkg::TW-1:0]         timed_out_thread,
	output logic [mtsw_pkg::TW-1:0]         timed_out_start,
	output logic                            table_full,
	output logic                            last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int RW = mtsw_pkg::RCW;
	localparam int TW = mtsw_pkg::TW;

	mtsw_pkg::state_t state_q, state_d;
	mtsw_pkg::op_t    op_q;
	mtsw_pkg::mode_t  mode_q;
	logic [TW-1:0]    tid_q;
	logic [TW-1:0]    time_q;
	logic [TW-1:0]    idle_since_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] rep_q;
	logic [CW-1:0]    count_q;

	// Scan pipeline
	logic [CW-1:0]    rd_idx_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;

	// Scan findings
	logic             match_v_q;
	logic [IW-1:0]    match_idx_q;
	logic             free_v_q;
	logic [IW-1:0]    free_idx_q;
	logic             full_q;
	logic [RW-1:0]    rep_cnt_q;
	logic             pend_v_q;
	logic [TW-1:0]    pend_tid_q;
	logic [TW-1:0]    pend_start_q;

	// Output register
	logic             out_valid_q;
	mtsw_pkg::mode_t  out_mode_q;
	logic             out_tv_q;
	logic [TW-1:0]    out_tid_q;
	logic [TW-1:0]    out_start_q;
	logic             out_full_q;
	logic             out_last_q;

	// Table memory: {thread, start}
	logic             ram_re;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [2*TW-1:0]  ram_wdata;
	logic [2*TW-1:0]  ram_rdata;
	logic [TW-1:0]    rd_thread;
	logic [TW-1:0]    rd_start;
	logic [TW-1:0]    elapsed;

	// Control strobes
	logic             out_free;
	logic             slot_live;
	logic             hit;
	logic             adv;
	logic             more;
	logic             scan_done;
	logic             scan_step;
	logic             push;
	logic             push_tv;
	logic [TW-1:0]    push_tid;
	logic [TW-1:0]    push_start;
	logic             push_full;
	logic             push_last;

	mtsw_ram #(
		.WIDTH (2 * TW),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// Slot evaluation on the read data
	assign rd_thread = ram_rdata[2*TW-1:TW];
	assign rd_start = ram_rdata[TW-1:0];
	assign elapsed = time_q - rd_start;
	assign slot_live = v_s1 && valid_q[idx_s1];
	assign hit = (op_q == mtsw_pkg::OP_TICK) && slot_live && !rep_q[idx_s1] &&
		(elapsed >= cfg.timeout) && (rep_cnt_q < RW'(mtsw_pkg::MAX_RESULTS));
	assign out_free = !out_valid_q || !out_stall;
	assign adv = !(hit && pend_v_q && !out_free);
	assign more = (rd_idx_q < CW'(SLOTS));
	assign scan_done = !more && !v_s1;

	// Table write on an accepted start
	assign ram_we = (state_q == mtsw_pkg::ST_APPLY) && (op_q == mtsw_pkg::OP_START) &&
		(match_v_q || free_v_q);
	assign ram_waddr = match_v_q ? match_idx_q : free_idx_q;
	assign ram_wdata = {tid_q, time_q};

	// Next state and strobes
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		ram_re = 1'b0;
		scan_step = 1'b0;
		push = 1'b0;
		push_tv = 1'b0;
		push_tid = '0;
		push_start = '0;
		push_full = 1'b0;
		push_last = 1'b0;
		case (state_q)
			mtsw_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						mtsw_pkg::OP_START:  state_d = mtsw_pkg::ST_SCAN;
						mtsw_pkg::OP_FINISH: state_d = mtsw_pkg::ST_SCAN;
						mtsw_pkg::OP_TICK:   state_d = mtsw_pkg::ST_TICK_INC;
						default:             state_d = mtsw_pkg::ST_RESULT;
					endcase
				end
			end
			mtsw_pkg::ST_TICK_INC: begin
				state_d = mtsw_pkg::ST_TICK_CHK;
			end
			mtsw_pkg::ST_TICK_CHK: begin
				state_d = (count_q != '0) ? mtsw_pkg::ST_SCAN : mtsw_pkg::ST_RESULT;
			end
			mtsw_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = (op_q == mtsw_pkg::OP_TICK) ? mtsw_pkg::ST_FLUSH :
						mtsw_pkg::ST_APPLY;
				end else if (adv) begin
					scan_step = 1'b1;
					ram_re = more;
					// a new report moves the held one out
					if (hit && pend_v_q) begin
						push = 1'b1;
						push_tv = 1'b1;
						push_tid = pend_tid_q;
						push_start = pend_start_q;
					end
				end
			end
			mtsw_pkg::ST_APPLY: begin
				state_d = (op_q == mtsw_pkg::OP_FINISH) ? mtsw_pkg::ST_FIN_CHK :
					mtsw_pkg::ST_RESULT;
			end
			mtsw_pkg::ST_FIN_CHK: begin
				state_d = mtsw_pkg::ST_RESULT;
			end
			mtsw_pkg::ST_RESULT: begin
				if (out_free) begin
					push = 1'b1;
					push_full = full_q;
					push_last = 1'b1;
					state_d = mtsw_pkg::ST_IDLE;
				end
			end
			mtsw_pkg::ST_FLUSH: begin
				if (out_free) begin
					push = 1'b1;
					push_tv = pend_v_q;
					push_tid = pend_v_q ? pend_tid_q : '0;
					push_start = pend_v_q ? pend_start_q : '0;
					push_last = 1'b1;
					state_d = mtsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtsw_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command capture and scan payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q <= cmd.op;
			tid_q <= cmd.tid;
		end
		if (scan_step && more) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
		if (scan_step && slot_live && (rd_thread == tid_q) && !match_v_q) begin
			match_idx_q <= idx_s1;
		end
		if (scan_step && v_s1 && !valid_q[idx_s1] && !free_v_q) begin
			free_idx_q <= idx_s1;
		end
		if (scan_step && hit) begin
			pend_tid_q <= rd_thread;
			pend_start_q <= rd_start;
			rep_q[idx_s1] <= 1'b1;
		end
		if (ram_we) begin
			rep_q[ram_waddr] <= 1'b0;
		end
	end

	// Control state, table occupancy and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mtsw_pkg::MODE_IDLE;
			time_q <= '0;
			idle_since_q <= '0;
			valid_q <= '0;
			count_q <= '0;
			rd_idx_q <= '0;
			v_s1 <= 1'b0;
			match_v_q <= 1'b0;
			free_v_q <= 1'b0;
			full_q <= 1'b0;
			rep_cnt_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				rd_idx_q <= '0;
				v_s1 <= 1'b0;
				match_v_q <= 1'b0;
				free_v_q <= 1'b0;
				full_q <= 1'b0;
				rep_cnt_q <= '0;
				pend_v_q <= 1'b0;
			end
			if (state_q == mtsw_pkg::ST_TICK_INC) begin
				time_q <= time_q + TW'(1);
			end
			// Tick mode update
			if (state_q == mtsw_pkg::ST_TICK_CHK) begin
				if (count_q != '0) begin
					mode_q <= mtsw_pkg::MODE_MONITOR;
				end else if (!(mode_q == mtsw_pkg::MODE_IDLE &&
						(time_q - idle_since_q) < cfg.idle_delay)) begin
					mode_q <= mtsw_pkg::MODE_SLEEP;
				end
			end
			// Scan advance
			if (scan_step) begin
				if (more) begin
					rd_idx_q <= rd_idx_q + CW'(1);
					v_s1 <= 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
				if (slot_live && (rd_thread == tid_q)) begin
					match_v_q <= 1'b1;
				end
				if (v_s1 && !valid_q[idx_s1]) begin
					free_v_q <= 1'b1;
				end
				if (hit) begin
					rep_cnt_q <= rep_cnt_q + RW'(1);
					pend_v_q <= 1'b1;
				end
			end
			// Apply start or finish
			if (state_q == mtsw_pkg::ST_APPLY) begin
				if (op_q == mtsw_pkg::OP_START) begin
					if (match_v_q || free_v_q) begin
						valid_q[ram_waddr] <= 1'b1;
						mode_q <= mtsw_pkg::MODE_MONITOR;
						if (!match_v_q) begin
							count_q <= count_q + CW'(1);
						end
					end else begin
						full_q <= 1'b1;
					end
				end else if (match_v_q) begin
					valid_q[match_idx_q] <= 1'b0;
					count_q <= count_q - CW'(1);
				end
			end
			// Empty table after a finish
			if (state_q == mtsw_pkg::ST_FIN_CHK && count_q == '0) begin
				idle_since_q <= time_q;
				mode_q <= mtsw_pkg::MODE_IDLE;
			end
			if (state_q == mtsw_pkg::ST_FLUSH && out_free) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register word
	always_ff @(posedge clk) begin
		if (push) begin
			out_mode_q <= mode_q;
			out_tv_q <= push_tv;
			out_tid_q <= push_tid;
			out_start_q <= push_start;
			out_full_q <= push_full;
			out_last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign mode = out_mode_q;
	assign timeout_valid = out_tv_q;
	assign timed_out_thread = out_tid_q;
	assign timed_out_start = out_start_q;
	assign table_full = out_full_q;
	assign last = out_last_q;

	`MTSW_CHECK(a_count_tracks_valid, $countones(valid_q) == int'(count_q), "slot count mismatch")
	`MTSW_CHECK(a_report_cap, rep_cnt_q <= RW'(mtsw_pkg::MAX_RESULTS), "report cap exceeded")
	`MTSW_IMPLIES(a_idle_no_pending, state_q == mtsw_pkg::ST_IDLE, !pend_v_q, "stale report")
	`MTSW_NEXT(a_start_monitors, ram_we, mode_q == mtsw_pkg::MODE_MONITOR && count_q != '0, "start not monitored")

endmodule

`default_nettype wire

// File: hdl/multi_task_stall_watchdog_top.sv
// Top level of the multi-task stall watchdog.
`default_nettype none

// Watchdog for up to SLOTS concurrently running tasks. Words on the input
// channel start a task, finish a task or mark one elapsed millisecond; each
// input word yields one or more result words, the final one flagged by last,
// and a tick reports every newly overdue task, up to MAX_RESULTS of them, as
// a word of its own. The front end takes words into a four-entry command
// queue; the back end handles one command at a time and walks the task
// table one slot per cycle through its single read port, unless a report
// waits on a stalled output. Starts, finishes and ticks with tasks in the
// table scan every slot, while ticks on an empty table and unused request
// codes skip the scan; the time the back end is busy, including time spent
// on a stalled output side, sets the sustained rate of input words.
// Configuration writes take effect at once and are meant for idle periods.
module multi_task_stall_watchdog_top #(
	parameter int SLOTS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wen,
	input  wire logic [mtsw_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [mtsw_pkg::TW-1:0]     cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [mtsw_pkg::REQ_W-1:0]  req_type,
	input  wire logic [mtsw_pkg::TW-1:0]     task_thread,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       mode,
	output logic                             timeout_valid,
	output logic [mtsw_pkg::TW-1:0]          timed_out_thread,
	output logic [mtsw_pkg::TW-1:0]          timed_out_start,
	output logic                             table_full,
	output logic                             last
);

	mtsw_pkg::cmd_t q_in;
	mtsw_pkg::cmd_t q_out;
	mtsw_pkg::cfg_t cfg;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_not_empty;

	mtsw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.task_thread (task_thread),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in),
		.cfg         (cfg)
	);

	mtsw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_not_empty)
	);

	mtsw_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd_valid        (q_not_empty),
		.cmd              (q_out),
		.cmd_pop          (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.mode             (mode),
		.timeout_valid    (timeout_valid),
		.timed_out_thread (timed_out_thread),
		.timed_out_start  (timed_out_start),
		.table_full       (table_full),
		.last             (last)
	);

endmodule

`default_nettype wire

// File: sim/tb_multi_task_stall_watchdog_top.sv
// Self-checking testbench for the multi-task stall watchdog top level.
`default_nettype none

module tb_multi_task_stall_watchdog_top;

	localparam int SLOTS = 16;
	localparam int POOL = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN = 10;
	localparam logic [mtsw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	// One result word as the block should produce it
	typedef struct {
		mtsw_pkg::mode_t         mode;
		logic                    overdue;
		logic [mtsw_pkg::TW-1:0] tid;
		logic [mtsw_pkg::TW-1:0] started;
		logic                    dropped;
		logic                    last;
	} watch_word_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_wen = 1'b0;
	logic [mtsw_pkg::CFG_IW-1:0]   cfg_index = '0;
	logic [mtsw_pkg::TW-1:0]       cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [mtsw_pkg::REQ_W-1:0]    req_type = '0;
	logic [mtsw_pkg::TW-1:0]       task_thread = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    mode;
	logic                          timeout_valid;
	logic [mtsw_pkg::TW-1:0]       timed_out_thread;
	logic [mtsw_pkg::TW-1:0]       timed_out_start;
	logic                          table_full;
	logic                          last;

	multi_task_stall_watchdog_top #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.task_thread(task_thread),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode(mode),
		.timeout_valid(timeout_valid),
		.timed_out_thread(timed_out_thread),
		.timed_out_start(timed_out_start),
		.table_full(table_full),
		.last(last)
	);

	// Predictor state: task table, clock, mode and registers
	logic                    slot_used [SLOTS];
	logic [mtsw_pkg::TW-1:0] slot_tid [SLOTS];
	logic [mtsw_pkg::TW-1:0] slot_t0 [SLOTS];
	logic                    slot_flagged [SLOTS];
	logic [mtsw_pkg::TW-1:0] ms_now;
	logic [mtsw_pkg::TW-1:0] idle_t0;
	mtsw_pkg::mode_t         cur_mode;
	logic [mtsw_pkg::TW-1:0] limit_ms;
	logic [mtsw_pkg::TW-1:0] sleep_after;

	watch_word_t             expected_words [$];
	logic [mtsw_pkg::TW-1:0] tid_pool [POOL];

	int mismatches = 0;
	int n_items = 0;
	int n_words = 0;
	int n_reports = 0;
	int n_dropped = 0;
	int n_sleeping = 0;
	int cycles = 0;
	bit send_steady = 0;
	bit recv_steady = 0;
	int recv_hold = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles,
				expected_words.size());
			$display("** multi_task_stall_watchdog_top: FAILED **");
			$finish;
		end
	end

	// Register write as the block stores it
	function automatic void apply_reg(input logic [mtsw_pkg::CFG_IW-1:0] idx,
			input logic [mtsw_pkg::TW-1:0] val);
		if (idx == mtsw_pkg::CFG_TASK_TIMEOUT)
			limit_ms = (val == '0) ? 32'd1 : val;
		else if (idx == mtsw_pkg::CFG_IDLE_DELAY)
			sleep_after = val;
	endfunction

	// Work out the result words of one accepted input word
	function automatic void predict_watchdog(input logic [mtsw_pkg::REQ_W-1:0] req,
			input logic [mtsw_pkg::TW-1:0] tid);
		watch_word_t             batch [mtsw_pkg::MAX_RESULTS];
		watch_word_t             blank;
		int                      nb;
		int                      hit;
		bit                      busy;
		logic [mtsw_pkg::TW-1:0] elapsed;

		blank = '{mode: cur_mode, overdue: 1'b0, tid: '0, started: '0, dropped: 1'b0,
			last: 1'b0};
		nb = 0;
		hit = -1;
		busy = 0;
		if (req == mtsw_pkg::REQ_START) begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_used[i] && slot_tid[i] == tid)
					hit = i;
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && !slot_used[i])
					hit = i;
			if (hit >= 0) begin
				slot_used[hit] = 1'b1;
				slot_tid[hit] = tid;
				slot_t0[hit] = ms_now;
				slot_flagged[hit] = 1'b0;
				cur_mode = mtsw_pkg::MODE_MONITOR;
			end
			batch[0] = blank;
			batch[0].mode = cur_mode;
			batch[0].dropped = (hit < 0);
			nb = 1;
		end else if (req == mtsw_pkg::REQ_FINISH) begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_used[i] && slot_tid[i] == tid)
					hit = i;
			if (hit >= 0)
				slot_used[hit] = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				busy |= slot_used[i];
			if (!busy) begin
				idle_t0 = ms_now;
				cur_mode = mtsw_pkg::MODE_IDLE;
			end
			batch[0] = blank;
			batch[0].mode = cur_mode;
			nb = 1;
		end else if (req == mtsw_pkg::REQ_TICK) begin
			ms_now = ms_now + 1;
			for (int i = 0; i < SLOTS; i++)
				busy |= slot_used[i];
			if (busy) begin
				cur_mode = mtsw_pkg::MODE_MONITOR;
				// scan in slot order, each overdue task reported once
				for (int i = 0; i < SLOTS; i++) begin
					elapsed = ms_now - slot_t0[i];
					if (nb < mtsw_pkg::MAX_RESULTS && slot_used[i] && !slot_flagged[i] &&
							elapsed >= limit_ms) begin
						slot_flagged[i] = 1'b1;
						batch[nb] = blank;
						batch[nb].overdue = 1'b1;
						batch[nb].tid = slot_tid[i];
						batch[nb].started = slot_t0[i];
						nb++;
					end
				end
			end else if (!(cur_mode == mtsw_pkg::MODE_IDLE &&
					(ms_now - idle_t0) < sleep_after)) begin
				cur_mode = mtsw_pkg::MODE_SLEEP;
			end
			if (nb == 0) begin
				batch[0] = blank;
				nb = 1;
			end
			for (int i = 0; i < nb; i++)
				batch[i].mode = cur_mode;
		end else begin
			batch[0] = blank;
			nb = 1;
		end
		batch[nb-1].last = 1'b1;
		for (int i = 0; i < nb; i++)
			expected_words.insert(expected_words.size(), batch[i]);
	endfunction

	// Per-word wait, with occasional runs of back-to-back traffic
	function automatic int pick_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// Result side: random stall before each word, compare against the oldest expectation
	always @(posedge clk) begin : check_results
		watch_word_t w;
		bit          bad;

		if (out_valid && !out_stall) begin
			n_words++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected word: mode %0d tv %0b thread %h start %h full %0b last %0b",
						mode, timeout_valid, timed_out_thread, timed_out_start, table_full, last);
			end else begin
				w = expected_words.pop_front();
				bad = (mode !== w.mode) || (timeout_valid !== w.overdue) ||
					(timed_out_thread !== w.tid) || (timed_out_start !== w.started) ||
					(table_full !== w.dropped) || (last !== w.last);
				if (bad) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("mismatch at cycle %0d:", cycles);
						$display("  expected mode %0d tv %0b thread %h start %h full %0b last %0b",
							w.mode, w.overdue, w.tid, w.started, w.dropped, w.last);
						$display("  actual   mode %0d tv %0b thread %h start %h full %0b last %0b",
							mode, timeout_valid, timed_out_thread, timed_out_start, table_full,
							last);
					end
				end
				if (w.overdue)
					n_reports++;
				if (w.dropped)
					n_dropped++;
				if (w.mode == mtsw_pkg::MODE_SLEEP)
					n_sleeping++;
			end
			if ($urandom_range(0, 31) == 0)
				recv_steady = !recv_steady;
			recv_hold = pick_gap(recv_steady);
		end else if (recv_hold != 0) begin
			recv_hold--;
		end
		out_stall <= (recv_hold != 0);
	end

	// Send one input word and predict its results once it is taken
	task automatic send_word(input logic [mtsw_pkg::REQ_W-1:0] req,
			input logic [mtsw_pkg::TW-1:0] tid);
		int gap;

		if ($urandom_range(0, 31) == 0)
			send_steady = !send_steady;
		gap = pick_gap(send_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		task_thread <= tid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_watchdog(req, tid);
		n_items++;
	endtask

	// Hold the sender until every expected word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_reg(input logic [mtsw_pkg::CFG_IW-1:0] idx,
			input logic [mtsw_pkg::TW-1:0] val);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		apply_reg(idx, val);
	endtask

	// Start, tick, unused code, stray finish, real finish and a final tick with reset registers
	task automatic test_basic_lifecycle();
		send_word(mtsw_pkg::REQ_START, 32'h1234_5678);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
		send_word(REQ_UNUSED, 32'hFFFF_FFFF);
		send_word(mtsw_pkg::REQ_FINISH, 32'hDEAD_BEEF);
		send_word(mtsw_pkg::REQ_FINISH, 32'h1234_5678);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
	endtask

	// Zero idle delay: an empty table sleeps on the next tick
	task automatic test_idle_to_sleep();
		write_reg(mtsw_pkg::CFG_IDLE_DELAY, 32'h0);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
	endtask

	// Fill every slot, drop one start, restart one, then one tick reports all of them and a second reports none
	task automatic test_table_full();
		write_reg(mtsw_pkg::CFG_TASK_TIMEOUT, 32'h0);
		write_reg(mtsw_pkg::CFG_IDLE_DELAY, 32'hFFFF_FFFF);
		for (int i = 0; i < SLOTS; i++)
			send_word(mtsw_pkg::REQ_START, tid_pool[i]);
		send_word(mtsw_pkg::REQ_START, tid_pool[SLOTS]);
		send_word(mtsw_pkg::REQ_START, tid_pool[3]);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
		send_word(mtsw_pkg::REQ_TICK, 32'h0);
	endtask

	// Mixed random traffic over a pool of thread ids of the given size
	task automatic test_random_traffic(input logic [mtsw_pkg::TW-1:0] tmo,
			input logic [mtsw_pkg::TW-1:0] idl, input int npool, input int count);
		int                      r;
		logic [mtsw_pkg::TW-1:0] tid;

		write_reg(mtsw_pkg::CFG_TASK_TIMEOUT, tmo);
		write_reg(mtsw_pkg::CFG_IDLE_DELAY, idl);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0)
				tid = $urandom;
			else
				tid = tid_pool[$urandom_range(0, npool - 1)];
			if (r < 30)
				send_word(mtsw_pkg::REQ_START, tid);
			else if (r < 60)
				send_word(mtsw_pkg::REQ_FINISH, tid);
			else if (r < 95)
				send_word(mtsw_pkg::REQ_TICK, tid);
			else
				send_word(REQ_UNUSED, tid);
		end
	endtask

	// Main sequence
	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_tid[i] = '0;
			slot_t0[i] = '0;
			slot_flagged[i] = 1'b0;
		end
		ms_now = '0;
		idle_t0 = '0;
		cur_mode = mtsw_pkg::MODE_IDLE;
		limit_ms = mtsw_pkg::TIMEOUT_RST;
		sleep_after = mtsw_pkg::IDLE_DELAY_RST;
		tid_pool[0] = 32'h0;
		tid_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL; i++)
			tid_pool[i] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_lifecycle();
		test_idle_to_sleep();
		test_table_full();
		test_random_traffic($urandom_range(2, 12), $urandom_range(0, 8), POOL, 90);
		test_random_traffic(32'hFFFF_FFFF, 32'h0, 4, 85);
		test_random_traffic(32'h1, 32'hFFFF_FFFF, 6, 85);
		test_random_traffic($urandom_range(3, 40), $urandom_range(1, 20), 3, 94);

		wait_drained();
		repeat (40) @(posedge clk);
		if (expected_words.size() != 0) begin
			$display("%0d expected words never arrived", expected_words.size());
			mismatches += expected_words.size();
		end

		$display("sent %0d input words, checked %0d result words, %0d mismatches",
			n_items, n_words, mismatches);
		$display("saw %0d timeout reports, %0d dropped starts, %0d words in sleep mode",
			n_reports, n_dropped, n_sleeping);
		if (mismatches == 0) begin
			$display("** multi_task_stall_watchdog_top: PASSED **");
		end else begin
			$display("** multi_task_stall_watchdog_top: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
